### src/pfbq_pkg.sv
// Shared types and constants for the per-flow byte quota policer.
// No dependencies; imported by the top level and the port checker.
package pfbq_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_PORT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_LIMIT = 2'd1;

   localparam logic [15:0] MATCH_PORT_RESET = 16'd80;
   localparam logic [30:0] BYTE_LIMIT_RESET = 31'd1000000;

   localparam logic [7:0] TCP_PROTOCOL = 8'd6;

   typedef enum logic [1:0] {
      OUTCOME_BYPASS = 2'd0,
      OUTCOME_EMPTY  = 2'd1,
      OUTCOME_ACCEPT = 2'd2,
      OUTCOME_DROP   = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [31:0] acc_pkts;
      logic [31:0] drop_pkts;
      logic [31:0] acc_bytes;
      logic [31:0] drop_bytes;
   } slot_type;

endpackage

### src/per_flow_byte_quota_policer_top.sv
// Per-flow byte quota policer: flow table in one RAM, hash, quota update.
// Depends on pfbq_pkg and pfbq_ram.
//
// An item is taken when start is high and busy is low. Busy is high from
// the accept until the item is through: the fields are captured, then the
// two parallel hash products are formed, then the final product and the
// flow table read, then the read-modify-write of the slot. The result
// appears on the rsp_ ports in the cycle after the update, with rsp_valid high
// for exactly one cycle; the receiver cannot stall it. After reset the
// table is cleared one slot a cycle, with busy high until the last slot is cleared;
// CSR writes are taken at any time but are meant for an idle block.
module per_flow_byte_quota_policer_top
   import pfbq_pkg::*;
#(
   parameter int TABLE_SIZE = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [7:0]             req_protocol,
   input  logic [31:0]            req_src_addr,
   input  logic [31:0]            req_dst_addr,
   input  logic [15:0]            req_src_port,
   input  logic [15:0]            req_dst_port,
   input  logic [15:0]            req_total_length,
   input  logic [3:0]             req_ip_header_words,
   input  logic [3:0]             req_tcp_header_words,
   input  logic                   req_fin_flag,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_outcome,
   output logic [11:0]            rsp_slot_index,
   output logic [31:0]            rsp_accepted_packets,
   output logic [31:0]            rsp_dropped_packets,
   output logic [31:0]            rsp_accepted_bytes,
   output logic [31:0]            rsp_dropped_bytes,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SIZE - 1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_LOOK  = 5'b01000,
      ST_UPD   = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [15:0]      match_port_ff, match_port_in;
   logic [30:0]      byte_limit_ff, byte_limit_in;

   logic             policed_ff;
   logic             fin_ff;
   logic [31:0]      payload_ff;
   logic [IDX_W-1:0] fa_ff, fb_ff, fc_ff, fd_ff;
   logic [IDX_W-1:0] p1_ff, p2_ff;
   logic [IDX_W-1:0] slot_ff;

   logic             rsp_valid_ff;
   outcome_type      rsp_outcome_ff;
   logic [11:0]      rsp_slot_ff;
   slot_type         rsp_cnt_ff;

   logic             accept;
   logic             policed;
   logic [31:0]      payload;
   logic [2*IDX_W-1:0] m1, m2, m3;
   logic [IDX_W-1:0] hash_slot;
   logic [IDX_W+11:0] slot_ext;

   slot_type         cur, upd;
   outcome_type      outcome;
   logic             upd_wr;

   logic             ram_we, ram_re;
   logic [IDX_W-1:0] ram_waddr;
   slot_type         ram_wdata;
   logic [$bits(slot_type)-1:0] ram_rdata;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   assign policed = (req_protocol == TCP_PROTOCOL) &&
                    ((req_src_port == match_port_ff) || (req_dst_port == match_port_ff));
   assign payload = {16'd0, req_total_length}
                  - {26'd0, req_ip_header_words, 2'b00}
                  - {26'd0, req_tcp_header_words, 2'b00};

   assign m1 = {{IDX_W{1'b0}}, fa_ff} * {{IDX_W{1'b0}}, fb_ff};
   assign m2 = {{IDX_W{1'b0}}, fc_ff} * {{IDX_W{1'b0}}, fd_ff};
   assign m3 = {{IDX_W{1'b0}}, p1_ff} * {{IDX_W{1'b0}}, p2_ff};
   assign hash_slot = m3[IDX_W-1:0];
   assign slot_ext  = {12'd0, slot_ff};

   // csr
   always_comb begin
      match_port_in = match_port_ff;
      byte_limit_in = byte_limit_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MATCH_PORT: match_port_in = csr_wr_data[15:0];
            CSR_BYTE_LIMIT: byte_limit_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // slot update
   always_comb begin
      cur     = slot_type'(ram_rdata);
      upd     = cur;
      outcome = OUTCOME_BYPASS;
      upd_wr  = 1'b0;
      if (!policed_ff) begin
         outcome = OUTCOME_BYPASS;
      end else if (payload_ff == 32'd0) begin
         outcome = OUTCOME_EMPTY;
         upd_wr  = fin_ff;
      end else if (cur.acc_bytes < {1'b0, byte_limit_ff}) begin
         outcome       = OUTCOME_ACCEPT;
         upd.acc_pkts  = cur.acc_pkts + 32'd1;
         upd.acc_bytes = cur.acc_bytes + payload_ff;
         upd_wr        = 1'b1;
      end else begin
         outcome        = OUTCOME_DROP;
         upd.drop_pkts  = cur.drop_pkts + 32'd1;
         upd.drop_bytes = cur.drop_bytes + payload_ff;
         upd_wr         = 1'b1;
      end
   end

   always_comb begin
      ram_re    = (state_ff == ST_LOOK);
      ram_we    = 1'b0;
      ram_waddr = slot_ff;
      ram_wdata = fin_ff ? slot_type'('0) : upd;
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = slot_type'('0);
      end else if (state_ff == ST_UPD) begin
         ram_we = upd_wr;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_LOOK;
         ST_LOOK: state_in = ST_UPD;
         ST_UPD:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         match_port_ff <= MATCH_PORT_RESET;
         byte_limit_ff <= BYTE_LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         match_port_ff <= match_port_in;
         byte_limit_ff <= byte_limit_in;
         rsp_valid_ff  <= (state_ff == ST_UPD);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         policed_ff <= policed;
         fin_ff     <= req_fin_flag;
         payload_ff <= payload;
         fa_ff      <= req_src_addr[IDX_W-1:0] + 1'b1;
         fb_ff      <= req_dst_addr[IDX_W-1:0] + 1'b1;
         fc_ff      <= req_src_port[IDX_W-1:0] + 1'b1;
         fd_ff      <= req_dst_port[IDX_W-1:0] + 1'b1;
      end
      if (state_ff == ST_MUL) begin
         p1_ff <= m1[IDX_W-1:0];
         p2_ff <= m2[IDX_W-1:0];
      end
      if (state_ff == ST_LOOK) begin
         slot_ff <= hash_slot;
      end
      if (state_ff == ST_UPD) begin
         rsp_outcome_ff <= outcome;
         rsp_slot_ff    <= policed_ff ? slot_ext[11:0] : 12'd0;
         rsp_cnt_ff     <= policed_ff ? upd : slot_type'('0);
      end
   end

   pfbq_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (hash_slot),
      .rd_data (ram_rdata)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_outcome          = rsp_outcome_ff;
   assign rsp_slot_index       = rsp_slot_ff;
   assign rsp_accepted_packets = rsp_cnt_ff.acc_pkts;
   assign rsp_dropped_packets  = rsp_cnt_ff.drop_pkts;
   assign rsp_accepted_bytes   = rsp_cnt_ff.acc_bytes;
   assign rsp_dropped_bytes    = rsp_cnt_ff.drop_bytes;

endmodule

### src/pfbq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pfbq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/pfbq_checker.sv
// Port-level checks for the per-flow byte quota policer, bound to the top.
// Depends on pfbq_pkg and per_flow_byte_quota_policer_top.
module pfbq_checker
   import pfbq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_outcome,
   input logic [11:0] rsp_slot_index,
   input logic [31:0] rsp_accepted_packets,
   input logic [31:0] rsp_dropped_packets,
   input logic [31:0] rsp_accepted_bytes,
   input logic [31:0] rsp_dropped_bytes
);

   // accepted item holds off the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy low right after an accepted item");

   // fixed latency from accept to result
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##4 rsp_valid)
      else $error("result missing four cycles after accept");

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results on consecutive cycles");

   a_bypass_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == OUTCOME_BYPASS) |->
         (rsp_slot_index == 12'd0) && (rsp_accepted_packets == 32'd0) &&
         (rsp_dropped_packets == 32'd0) && (rsp_accepted_bytes == 32'd0) &&
         (rsp_dropped_bytes == 32'd0))
      else $error("bypass result carries slot data");

endmodule

bind per_flow_byte_quota_policer_top pfbq_checker u_pfbq_checker (.*);

### sim/tb.sv
// Testbench for per_flow_byte_quota_policer_top: directed and random packet headers,
// checked against an in-bench flow table predictor. Depends on pfbq_pkg and
// the policer RTL (per_flow_byte_quota_policer_top, pfbq_ram).
`timescale 1ns / 1ps

module tb;
   import pfbq_pkg::*;

   localparam int SLOTS       = 4096;
   localparam int STALL_LIMIT = 20000;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct {
      logic [7:0]  protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] total_length;
      logic [3:0]  ip_header_words;
      logic [3:0]  tcp_header_words;
      logic        fin_flag;
   } packet_hdr_type;

   typedef struct {
      outcome_type outcome;
      logic [11:0] slot;
      logic [31:0] acc_pkts;
      logic [31:0] drop_pkts;
      logic [31:0] acc_bytes;
      logic [31:0] drop_bytes;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        start                = 1'b0;
   logic        busy;
   logic [7:0]  req_protocol         = '0;
   logic [31:0] req_src_addr         = '0;
   logic [31:0] req_dst_addr         = '0;
   logic [15:0] req_src_port         = '0;
   logic [15:0] req_dst_port         = '0;
   logic [15:0] req_total_length     = '0;
   logic [3:0]  req_ip_header_words  = '0;
   logic [3:0]  req_tcp_header_words = '0;
   logic        req_fin_flag         = 1'b0;

   logic        rsp_valid;
   logic [1:0]  rsp_outcome;
   logic [11:0] rsp_slot_index;
   logic [31:0] rsp_accepted_packets;
   logic [31:0] rsp_dropped_packets;
   logic [31:0] rsp_accepted_bytes;
   logic [31:0] rsp_dropped_bytes;

   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = CSR_MATCH_PORT;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   // predictor state
   logic [15:0] pol_match_port;
   logic [30:0] pol_byte_limit;
   logic [31:0] flow_acc_pkts  [SLOTS];
   logic [31:0] flow_drop_pkts [SLOTS];
   logic [31:0] flow_acc_bytes [SLOTS];
   logic [31:0] flow_drop_bytes[SLOTS];

   packet_hdr_type pending_packets[$];
   verdict_type    expected_verdicts[$];
   packet_hdr_type cur_pkt;

   int gap_left     = 0;
   int no_gap_left  = 0;
   int err_count    = 0;
   int rsp_count    = 0;
   int stall_cycles = 0;

   per_flow_byte_quota_policer_top #(.TABLE_SIZE(SLOTS)) dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_protocol         (req_protocol),
      .req_src_addr         (req_src_addr),
      .req_dst_addr         (req_dst_addr),
      .req_src_port         (req_src_port),
      .req_dst_port         (req_dst_port),
      .req_total_length     (req_total_length),
      .req_ip_header_words  (req_ip_header_words),
      .req_tcp_header_words (req_tcp_header_words),
      .req_fin_flag         (req_fin_flag),
      .rsp_valid            (rsp_valid),
      .rsp_outcome          (rsp_outcome),
      .rsp_slot_index       (rsp_slot_index),
      .rsp_accepted_packets (rsp_accepted_packets),
      .rsp_dropped_packets  (rsp_dropped_packets),
      .rsp_accepted_bytes   (rsp_accepted_bytes),
      .rsp_dropped_bytes    (rsp_dropped_bytes),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wr_data          (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic verdict_type police_packet(packet_hdr_type p);
      verdict_type v;
      logic [31:0] h;
      logic [31:0] payload;
      logic [11:0] s;
      v.outcome    = OUTCOME_BYPASS;
      v.slot       = '0;
      v.acc_pkts   = '0;
      v.drop_pkts  = '0;
      v.acc_bytes  = '0;
      v.drop_bytes = '0;
      if (p.protocol != TCP_PROTOCOL ||
          (p.src_port != pol_match_port && p.dst_port != pol_match_port))
         return v;
      h = {20'd0, p.src_addr[11:0]} + 32'd1;
      h = (h * ({20'd0, p.dst_addr[11:0]} + 32'd1)) & (SLOTS - 1);
      h = (h * ({20'd0, p.src_port[11:0]} + 32'd1)) & (SLOTS - 1);
      h = (h * ({20'd0, p.dst_port[11:0]} + 32'd1)) & (SLOTS - 1);
      s = h[11:0];
      payload = {16'd0, p.total_length} - {26'd0, p.ip_header_words, 2'b00}
              - {26'd0, p.tcp_header_words, 2'b00};
      if (payload == 32'd0) begin
         v.outcome = OUTCOME_EMPTY;
      end else if (flow_acc_bytes[s] < {1'b0, pol_byte_limit}) begin
         v.outcome = OUTCOME_ACCEPT;
         flow_acc_pkts[s]  = flow_acc_pkts[s] + 32'd1;
         flow_acc_bytes[s] = flow_acc_bytes[s] + payload;
      end else begin
         v.outcome = OUTCOME_DROP;
         flow_drop_pkts[s]  = flow_drop_pkts[s] + 32'd1;
         flow_drop_bytes[s] = flow_drop_bytes[s] + payload;
      end
      v.slot       = s;
      v.acc_pkts   = flow_acc_pkts[s];
      v.drop_pkts  = flow_drop_pkts[s];
      v.acc_bytes  = flow_acc_bytes[s];
      v.drop_bytes = flow_drop_bytes[s];
      if (p.fin_flag) begin
         flow_acc_pkts[s]   = '0;
         flow_drop_pkts[s]  = '0;
         flow_acc_bytes[s]  = '0;
         flow_drop_bytes[s] = '0;
      end
      return v;
   endfunction

   task automatic flag_mismatch(string msg);
      err_count++;
      $display("tb: mismatch at result %0d: %s", rsp_count, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // driver: present one item at a time, random gap after each accept except in random runs with no gap
   always @(posedge clock) begin : drive
      logic go;
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         go = start;
         if (start && !busy) begin
            expected_verdicts.push_back(police_packet(cur_pkt));
            go = 1'b0;
            if (no_gap_left > 0) begin
               no_gap_left--;
               gap_left = 0;
            end else if ($urandom_range(0, 19) == 0) begin
               no_gap_left = $urandom_range(8, 32);
               gap_left = 0;
            end else begin
               gap_left = $urandom_range(0, 15);
            end
         end
         if (!go) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_packets.size() != 0) begin
               cur_pkt = pending_packets.pop_front();
               req_protocol         <= cur_pkt.protocol;
               req_src_addr         <= cur_pkt.src_addr;
               req_dst_addr         <= cur_pkt.dst_addr;
               req_src_port         <= cur_pkt.src_port;
               req_dst_port         <= cur_pkt.dst_port;
               req_total_length     <= cur_pkt.total_length;
               req_ip_header_words  <= cur_pkt.ip_header_words;
               req_tcp_header_words <= cur_pkt.tcp_header_words;
               req_fin_flag         <= cur_pkt.fin_flag;
               go = 1'b1;
            end
         end
         start <= go;
      end
   end

   // monitor
   always @(posedge clock) begin : watch
      verdict_type ev;
      if (!reset && rsp_valid) begin
         if (expected_verdicts.size() == 0) begin
            flag_mismatch("result with no item pending");
         end else begin
            ev = expected_verdicts.pop_front();
            check_field("outcome", {30'd0, rsp_outcome}, {30'd0, ev.outcome});
            check_field("slot_index", {20'd0, rsp_slot_index}, {20'd0, ev.slot});
            check_field("accepted_packets", rsp_accepted_packets, ev.acc_pkts);
            check_field("dropped_packets", rsp_dropped_packets, ev.drop_pkts);
            check_field("accepted_bytes", rsp_accepted_bytes, ev.acc_bytes);
            check_field("dropped_bytes", rsp_dropped_bytes, ev.drop_bytes);
         end
         rsp_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic push_pkt(logic [7:0] proto, logic [31:0] sa, logic [31:0] da,
                           logic [15:0] sp, logic [15:0] dp, logic [15:0] tot,
                           logic [3:0] ihl, logic [3:0] doff, logic fin);
      packet_hdr_type p;
      p.protocol         = proto;
      p.src_addr         = sa;
      p.dst_addr         = da;
      p.src_port         = sp;
      p.dst_port         = dp;
      p.total_length     = tot;
      p.ip_header_words  = ihl;
      p.tcp_header_words = doff;
      p.fin_flag         = fin;
      pending_packets.push_back(p);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_MATCH_PORT: pol_match_port = data[15:0];
         CSR_BYTE_LIMIT: pol_byte_limit = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // wait until every item is taken and every result is back
   task automatic drain();
      @(negedge clock);
      while (pending_packets.size() != 0 || start || expected_verdicts.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // mostly well-formed packets of a small flow set, some random noise
   task automatic random_phase(int n);
      logic [31:0] fsa[8];
      logic [31:0] fda[8];
      logic [15:0] fsp[8];
      logic [15:0] fdp[8];
      packet_hdr_type p;
      int k;
      int r;
      int payload;
      for (int i = 0; i < 8; i++) begin
         fsa[i] = $urandom;
         fda[i] = $urandom;
         if ($urandom_range(0, 1)) begin
            fsp[i] = pol_match_port;
            fdp[i] = 16'($urandom);
         end else begin
            fsp[i] = 16'($urandom);
            fdp[i] = pol_match_port;
         end
      end
      // swapped addresses hash to the same slot
      fsa[7] = fda[6];
      fda[7] = fsa[6];
      fsp[7] = fsp[6];
      fdp[7] = fdp[6];
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 2) begin
            p.protocol         = ($urandom_range(0, 2) == 0) ? 8'($urandom) : TCP_PROTOCOL;
            p.src_addr         = $urandom;
            p.dst_addr         = $urandom;
            p.src_port         = 16'($urandom);
            p.dst_port         = ($urandom_range(0, 2) == 0) ? pol_match_port : 16'($urandom);
            p.total_length     = 16'($urandom);
            p.ip_header_words  = 4'($urandom);
            p.tcp_header_words = 4'($urandom);
            p.fin_flag         = 1'($urandom);
         end else begin
            k = $urandom_range(0, 7);
            p.protocol         = TCP_PROTOCOL;
            p.src_addr         = fsa[k];
            p.dst_addr         = fda[k];
            p.src_port         = fsp[k];
            p.dst_port         = fdp[k];
            p.ip_header_words  = 4'($urandom_range(5, 15));
            p.tcp_header_words = 4'($urandom_range(5, 15));
            r = $urandom_range(0, 19);
            payload = (r == 0) ? 0 : $urandom_range(1, 1500);
            p.total_length = 16'(4 * (p.ip_header_words + p.tcp_header_words) + payload);
            if (r == 1)
               p.total_length = 16'($urandom_range(0, 100));
            p.fin_flag = ($urandom_range(0, 15) == 0);
         end
         pending_packets.push_back(p);
      end
   endtask

   initial begin
      pol_match_port = MATCH_PORT_RESET;
      pol_byte_limit = BYTE_LIMIT_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         flow_acc_pkts[i]   = '0;
         flow_drop_pkts[i]  = '0;
         flow_acc_bytes[i]  = '0;
         flow_drop_bytes[i] = '0;
      end

      // directed, reset config: port 80, limit 1000000
      push_pkt(8'd0, 32'h0A000001, 32'hC0A80002, 16'd80, 16'd80, 16'd100, 4'd5, 4'd5, 1'b0);
      push_pkt(8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd80, 16'd80, 16'd1040, 4'd5, 4'd5, 1'b1);
      push_pkt(TCP_PROTOCOL, 32'h0A000001, 32'hC0A80002, 16'd81, 16'd8080, 16'd1040,
               4'd5, 4'd5, 1'b0);
      push_pkt(TCP_PROTOCOL, 32'h0A000001, 32'hC0A80002, 16'd40000, 16'd80, 16'd1040,
               4'd5, 4'd5, 1'b0);
      push_pkt(TCP_PROTOCOL, 32'h0A000001, 32'hC0A80002, 16'd40000, 16'd80, 16'd540,
               4'd5, 4'd5, 1'b0);
      push_pkt(TCP_PROTOCOL, 32'hC0A80002, 32'h0A000001, 16'd40000, 16'd80, 16'd300,
               4'd5, 4'd5, 1'b0);
      push_pkt(TCP_PROTOCOL, 32'h0A000001, 32'hC0A80002, 16'd40000, 16'd80, 16'd40,
               4'd5, 4'd5, 1'b0);
      push_pkt(TCP_PROTOCOL, 32'h0A000001, 32'hC0A80002, 16'd40000, 16'd80, 16'd40,
               4'd5, 4'd5, 1'b1);
      push_pkt(TCP_PROTOCOL, 32'h0A000001, 32'hC0A80002, 16'd40000, 16'd80, 16'd200,
               4'd5, 4'd5, 1'b0);
      push_pkt(TCP_PROTOCOL, 32'h0B0B0B0B, 32'h0C0C0C0C, 16'd80, 16'd5555, 16'd0,
               4'd15, 4'd15, 1'b0);
      push_pkt(TCP_PROTOCOL, 32'h0B0B0B0B, 32'h0C0C0C0C, 16'd80, 16'd5555, 16'd1500,
               4'd5, 4'd8, 1'b0);
      push_pkt(TCP_PROTOCOL, 32'h0B0B0B0B, 32'h0C0C0C0C, 16'd80, 16'd5555, 16'd0,
               4'd15, 4'd15, 1'b0);
      push_pkt(TCP_PROTOCOL, 32'h0B0B0B0B, 32'h0C0C0C0C, 16'd80, 16'd5555, 16'd0,
               4'd15, 4'd15, 1'b0);
      push_pkt(TCP_PROTOCOL, 32'h0B0B0B0B, 32'h0C0C0C0C, 16'd80, 16'd5555, 16'd100,
               4'd5, 4'd5, 1'b1);
      push_pkt(TCP_PROTOCOL, 32'h0B0B0B0B, 32'h0C0C0C0C, 16'd80, 16'd5555, 16'd100,
               4'd5, 4'd5, 1'b0);
      push_pkt(TCP_PROTOCOL, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd80, 16'hFFFF, 16'hFFFF,
               4'hF, 4'hF, 1'b0);
      push_pkt(TCP_PROTOCOL, 32'h00000000, 32'h00000000, 16'd0, 16'd80, 16'd0,
               4'd0, 4'd0, 1'b1);
      push_pkt(TCP_PROTOCOL, 32'h00000000, 32'h00000000, 16'd0, 16'd80, 16'hFFFF,
               4'd0, 4'd0, 1'b0);
      push_pkt(TCP_PROTOCOL, 32'h00000000, 32'h00000000, 16'd0, 16'd80, 16'd52,
               4'd5, 4'd8, 1'b1);
      push_pkt(8'd17, 32'h0A000001, 32'hC0A80002, 16'd40000, 16'd80, 16'd1040,
               4'd5, 4'd5, 1'b1);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      drain();
      write_csr(CSR_MATCH_PORT, {15'h7FFF, 16'd443});
      write_csr(CSR_BYTE_LIMIT, 31'd2000);
      random_phase(170);

      drain();
      write_csr(CSR_MATCH_PORT, 31'd0);
      write_csr(CSR_BYTE_LIMIT, 31'd0);
      random_phase(150);

      drain();
      write_csr(CSR_MATCH_PORT, 31'h0000FFFF);
      write_csr(CSR_BYTE_LIMIT, 31'h7FFFFFFF);
      random_phase(170);

      drain();
      write_csr(CSR_MATCH_PORT, 31'($urandom));
      write_csr(CSR_BYTE_LIMIT, 31'd20000);
      write_csr(CSR_SPARE_2, 31'($urandom));
      write_csr(CSR_SPARE_3, 31'h7FFFFFFF);
      random_phase(170);

      drain();
      write_csr(CSR_MATCH_PORT, 31'd80);
      write_csr(CSR_BYTE_LIMIT, 31'($urandom_range(1000, 50000)));
      random_phase(200);

      drain();
      write_csr(CSR_MATCH_PORT, 31'($urandom));
      write_csr(CSR_BYTE_LIMIT, 31'(BYTE_LIMIT_RESET));
      random_phase(170);

      drain();
      if (err_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

### filelist.f
src/pfbq_pkg.sv
src/pfbq_ram.sv
src/per_flow_byte_quota_policer_top.sv
src/pfbq_checker.sv
sim/tb.sv
